FILE: src/bdq_pkg.sv
// shared constants, codes and types for the bounded deque with search
package bdq_pkg;

   localparam int DEPTH    = 16;
   localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int ACTION_W = 3;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_CONTAINS   = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_REMOVE     = 3'd5;
   localparam logic [ACTION_W-1:0] ACT_QUERY      = 3'd6;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   typedef logic [VALUE_W-1:0] word_type;

   // command broadcast to every cell of the row
   typedef struct packed {
      logic             fire;
      logic             push_front;
      logic             push_back;
      logic             pop_front;
      logic             remove;
      word_type         value;
      logic [CNT_W-1:0] count;
   } cell_cmd_type;

endpackage

FILE: src/bdq_if.sv
// request and response channel interfaces
interface bdq_req_if;
   logic                              valid;
   logic                              ready;
   logic [bdq_pkg::ACTION_W-1:0]      action;
   logic signed [bdq_pkg::VALUE_W-1:0] value;

   modport source (output valid, output action, output value, input ready);
   modport sink (input valid, input action, input value, output ready);
endinterface

interface bdq_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [bdq_pkg::STATUS_W-1:0]       status;
   logic                               found;
   logic signed [bdq_pkg::VALUE_W-1:0] front_value;
   logic signed [bdq_pkg::VALUE_W-1:0] back_value;
   logic [bdq_pkg::COUNT_W-1:0]        count;
   logic                               is_empty;

   modport source (output valid, output status, output found, output front_value,
                   output back_value, output count, output is_empty, input ready);
   modport sink (input valid, input status, input found, input front_value,
                 input back_value, input count, input is_empty, output ready);
endinterface

FILE: src/bdq_cell.sv
// one storage cell of the deque row with local compare and neighbor shift
module bdq_cell (
   input  logic                       clock,
   input  logic [bdq_pkg::IDX_W-1:0]  cell_index,
   input  bdq_pkg::cell_cmd_type      cmd,
   input  bdq_pkg::word_type          left_data,
   input  bdq_pkg::word_type          right_data,
   input  logic                       hit_prev,
   output logic                       hit_out,
   output bdq_pkg::word_type          data_out,
   output bdq_pkg::word_type          data_next
);

   bdq_pkg::word_type               data_ff;
   bdq_pkg::word_type               data_in;
   logic [bdq_pkg::CNT_W-1:0]       index_wide;
   logic                            occupied;
   logic                            at_tail;
   logic                            match;

   assign index_wide = bdq_pkg::CNT_W'(cell_index);
   assign occupied   = index_wide < cmd.count;
   assign at_tail    = index_wide == cmd.count;
   assign match      = occupied && (data_ff == cmd.value);
   assign hit_out    = hit_prev | match;

   always_comb begin
      data_in = data_ff;
      priority if (cmd.push_front) begin
         data_in = (cell_index == '0) ? cmd.value : left_data;
      end else if (cmd.push_back) begin
         if (at_tail) begin
            data_in = cmd.value;
         end
      end else if (cmd.pop_front) begin
         data_in = right_data;
      end else if (cmd.remove && hit_out) begin
         data_in = right_data;
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fire) begin
         data_ff <= data_in;
      end
   end

   assign data_out  = data_ff;
   assign data_next = data_in;

endmodule

FILE: src/bdq_row.sv
// row of cells chained for shifting and first-match search
module bdq_row (
   input  logic                   clock,
   input  bdq_pkg::cell_cmd_type  cmd,
   output logic                   found,
   output bdq_pkg::word_type      next_data [bdq_pkg::DEPTH]
);

   bdq_pkg::word_type cur_data [bdq_pkg::DEPTH];
   logic [bdq_pkg::DEPTH:0] hit_chain;

   assign hit_chain[0] = 1'b0;

   for (genvar i = 0; i < bdq_pkg::DEPTH; i++) begin : g_cell
      bdq_pkg::word_type left_data;
      bdq_pkg::word_type right_data;

      if (i == 0) begin : g_first
         assign left_data = cmd.value;
      end else begin : g_mid_left
         assign left_data = cur_data[i-1];
      end

      if (i == bdq_pkg::DEPTH - 1) begin : g_last
         assign right_data = '0;
      end else begin : g_mid_right
         assign right_data = cur_data[i+1];
      end

      bdq_cell u_cell (
         .clock      (clock),
         .cell_index (bdq_pkg::IDX_W'(i)),
         .cmd        (cmd),
         .left_data  (left_data),
         .right_data (right_data),
         .hit_prev   (hit_chain[i]),
         .hit_out    (hit_chain[i+1]),
         .data_out   (cur_data[i]),
         .data_next  (next_data[i])
      );
   end

   assign found = hit_chain[bdq_pkg::DEPTH];

endmodule

FILE: src/bounded_deque_with_bag_search_unit.sv
// top level of the bounded deque with value search and first-match removal
//
//   port      dir   handshake      word
//   req_port  in    valid/ready    action, value
//   rsp_port  out   valid/ready    status, found, front_value, back_value, count, is_empty
//
// one word is taken per cycle unless a result waits and the sink holds it; its result word appears in the next cycle
// the cell row updates in the accepting cycle: shift, compare and first-match
// chain all settle in one pass through the row
// the result register is the skid stage: a new word is taken while a result
// waits if the sink takes that result in the same cycle
// reset clears the count and the result valid; cell contents are not reset
module bounded_deque_with_bag_search_unit (
   input  logic      clock,
   input  logic      reset,
   bdq_req_if.sink   req_port,
   bdq_rsp_if.source rsp_port
);

   logic                            accept;
   logic [bdq_pkg::CNT_W-1:0]       count_ff;
   logic [bdq_pkg::CNT_W-1:0]       count_in;
   logic                            full;
   logic                            empty;
   logic                            row_found;
   bdq_pkg::cell_cmd_type           cmd;
   bdq_pkg::word_type               next_data [bdq_pkg::DEPTH];
   logic [bdq_pkg::STATUS_W-1:0]    status;
   logic                            found;
   logic [bdq_pkg::CNT_W-1:0]       back_pos;
   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   logic [bdq_pkg::STATUS_W-1:0]    rsp_status_ff;
   logic                            rsp_found_ff;
   bdq_pkg::word_type               rsp_front_ff;
   bdq_pkg::word_type               rsp_back_ff;
   logic [bdq_pkg::COUNT_W-1:0]     rsp_count_ff;
   logic                            rsp_empty_ff;

   assign req_port.ready = !rsp_valid_ff || rsp_port.ready;
   assign accept         = req_port.valid && req_port.ready;
   assign full           = count_ff == bdq_pkg::CNT_W'(bdq_pkg::DEPTH);
   assign empty          = count_ff == '0;

   always_comb begin
      cmd            = '0;
      cmd.fire       = accept;
      cmd.value      = req_port.value;
      cmd.count      = count_ff;
      status         = bdq_pkg::ST_OK;
      found          = 1'b0;
      count_in       = count_ff;
      unique case (req_port.action)
         bdq_pkg::ACT_PUSH_FRONT: begin
            if (full) begin
               status = bdq_pkg::ST_FULL;
            end else begin
               cmd.push_front = 1'b1;
               count_in       = count_ff + 1'b1;
            end
         end
         bdq_pkg::ACT_PUSH_BACK: begin
            if (full) begin
               status = bdq_pkg::ST_FULL;
            end else begin
               cmd.push_back = 1'b1;
               count_in      = count_ff + 1'b1;
            end
         end
         bdq_pkg::ACT_POP_FRONT: begin
            if (empty) begin
               status = bdq_pkg::ST_EMPTY;
            end else begin
               cmd.pop_front = 1'b1;
               count_in      = count_ff - 1'b1;
            end
         end
         bdq_pkg::ACT_POP_BACK: begin
            if (empty) begin
               status = bdq_pkg::ST_EMPTY;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
         bdq_pkg::ACT_CONTAINS: begin
            found = row_found;
         end
         bdq_pkg::ACT_REMOVE: begin
            if (empty) begin
               status = bdq_pkg::ST_EMPTY;
            end else begin
               cmd.remove = 1'b1;
               found      = row_found;
               if (row_found) begin
                  count_in = count_ff - 1'b1;
               end
            end
         end
         default: begin
            status = bdq_pkg::ST_OK;
         end
      endcase
   end

   bdq_row u_row (
      .clock     (clock),
      .cmd       (cmd),
      .found     (row_found),
      .next_data (next_data)
   );

   assign back_pos     = count_in - 1'b1;
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_port.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff <= status;
         rsp_found_ff  <= found;
         rsp_count_ff  <= bdq_pkg::COUNT_W'(count_in);
         rsp_empty_ff  <= count_in == '0;
         if (count_in == '0) begin
            rsp_front_ff <= '0;
            rsp_back_ff  <= '0;
         end else begin
            rsp_front_ff <= next_data[0];
            rsp_back_ff  <= next_data[back_pos[bdq_pkg::IDX_W-1:0]];
         end
      end
   end

   assign rsp_port.valid       = rsp_valid_ff;
   assign rsp_port.status      = rsp_status_ff;
   assign rsp_port.found       = rsp_found_ff;
   assign rsp_port.front_value = rsp_front_ff;
   assign rsp_port.back_value  = rsp_back_ff;
   assign rsp_port.count       = rsp_count_ff;
   assign rsp_port.is_empty    = rsp_empty_ff;

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= bdq_pkg::CNT_W'(bdq_pkg::DEPTH))
      else $error("count beyond depth");

   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted word without result");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      accept && !full && (req_port.action == bdq_pkg::ACT_PUSH_FRONT ||
                          req_port.action == bdq_pkg::ACT_PUSH_BACK)
      |=> count_ff == $past(count_ff) + 1'b1)
      else $error("push did not grow count");

   a_refused_not_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != bdq_pkg::ST_OK |-> !rsp_found_ff)
      else $error("refused word reports a match");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_empty_ff |-> rsp_count_ff == '0 && rsp_front_ff == '0)
      else $error("empty result carries data");

endmodule

FILE: tb/bdq_result_checker.sv
// checker that predicts the deque results and compares them with the response words
module bdq_result_checker (
   input  logic clock,
   input  logic reset,
   bdq_req_if   req_mon,
   bdq_rsp_if   rsp_mon,
   output int   mismatches,
   output int   outstanding,
   output int   results_checked,
   output int   refusals,
   output int   search_hits
);

   typedef struct packed {
      logic [bdq_pkg::STATUS_W-1:0] status;
      logic                         found;
      bdq_pkg::word_type            front_value;
      bdq_pkg::word_type            back_value;
      logic [bdq_pkg::COUNT_W-1:0]  count;
      logic                         is_empty;
   } deque_view_type;

   bdq_pkg::word_type stored_q[$];
   deque_view_type    expected_q[$];
   int                mismatch_total = 0;
   int                checked_total = 0;
   int                refusal_total = 0;
   int                hit_total = 0;

   function automatic deque_view_type apply_word(input logic [bdq_pkg::ACTION_W-1:0] act,
                                                 input bdq_pkg::word_type v);
      deque_view_type view;
      int             hit_idx;
      view = '0;
      view.status = bdq_pkg::ST_OK;
      hit_idx = -1;
      for (int i = 0; i < stored_q.size(); i++)
         if (hit_idx < 0 && stored_q[i] == v) hit_idx = i;
      case (act)
         bdq_pkg::ACT_PUSH_FRONT: begin
            if (stored_q.size() >= bdq_pkg::DEPTH) view.status = bdq_pkg::ST_FULL;
            else stored_q.push_front(v);
         end
         bdq_pkg::ACT_PUSH_BACK: begin
            if (stored_q.size() >= bdq_pkg::DEPTH) view.status = bdq_pkg::ST_FULL;
            else stored_q.push_back(v);
         end
         bdq_pkg::ACT_POP_FRONT: begin
            if (stored_q.size() == 0) view.status = bdq_pkg::ST_EMPTY;
            else void'(stored_q.pop_front());
         end
         bdq_pkg::ACT_POP_BACK: begin
            if (stored_q.size() == 0) view.status = bdq_pkg::ST_EMPTY;
            else void'(stored_q.pop_back());
         end
         bdq_pkg::ACT_CONTAINS: begin
            view.found = (hit_idx >= 0);
         end
         bdq_pkg::ACT_REMOVE: begin
            if (stored_q.size() == 0) begin
               view.status = bdq_pkg::ST_EMPTY;
            end else if (hit_idx >= 0) begin
               view.found = 1'b1;
               stored_q.delete(hit_idx);
            end
         end
         default: ;
      endcase
      if (stored_q.size() > 0) begin
         view.front_value = stored_q[0];
         view.back_value  = stored_q[stored_q.size()-1];
      end
      view.count    = bdq_pkg::COUNT_W'(stored_q.size());
      view.is_empty = (stored_q.size() == 0);
      return view;
   endfunction

   task automatic report_mismatch(input string field, input bdq_pkg::word_type got,
                                  input bdq_pkg::word_type want);
      $display("mismatch at result %0d: %s got %h expected %h", checked_total, field, got, want);
      mismatch_total++;
   endtask

   task automatic compare_view(input deque_view_type got, input deque_view_type want);
      if (got.status !== want.status)
         report_mismatch("status", bdq_pkg::word_type'(got.status),
                         bdq_pkg::word_type'(want.status));
      if (got.found !== want.found)
         report_mismatch("found", bdq_pkg::word_type'(got.found),
                         bdq_pkg::word_type'(want.found));
      if (got.front_value !== want.front_value)
         report_mismatch("front_value", got.front_value, want.front_value);
      if (got.back_value !== want.back_value)
         report_mismatch("back_value", got.back_value, want.back_value);
      if (got.count !== want.count)
         report_mismatch("count", bdq_pkg::word_type'(got.count),
                         bdq_pkg::word_type'(want.count));
      if (got.is_empty !== want.is_empty)
         report_mismatch("is_empty", bdq_pkg::word_type'(got.is_empty),
                         bdq_pkg::word_type'(want.is_empty));
   endtask

   always @(posedge clock) begin
      deque_view_type got;
      deque_view_type want;
      if (reset) begin
         stored_q.delete();
         expected_q.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.status      = rsp_mon.status;
            got.found       = rsp_mon.found;
            got.front_value = rsp_mon.front_value;
            got.back_value  = rsp_mon.back_value;
            got.count       = rsp_mon.count;
            got.is_empty    = rsp_mon.is_empty;
            if (expected_q.size() == 0) begin
               report_mismatch("result word with nothing pending", got.front_value, '0);
            end else begin
               compare_view(got, expected_q.pop_front());
            end
            checked_total++;
         end
         if (req_mon.valid && req_mon.ready) begin
            want = apply_word(req_mon.action, req_mon.value);
            if (want.status != bdq_pkg::ST_OK) refusal_total++;
            if (want.found) hit_total++;
            expected_q.push_back(want);
         end
      end
      mismatches      <= mismatch_total;
      outstanding     <= expected_q.size();
      results_checked <= checked_total;
      refusals        <= refusal_total;
      search_hits     <= hit_total;
   end

endmodule

FILE: tb/tb_bounded_deque_with_bag_search_unit.sv
// testbench top: stimulus, idling, watchdog and verdict for the deque with search
module tb_bounded_deque_with_bag_search_unit;

   localparam logic [bdq_pkg::ACTION_W-1:0] ACT_UNUSED = 3'd7;
   localparam int RANDOM_WORDS = 1230;
   localparam int SEGMENT_LEN  = 60;
   localparam int STALL_LIMIT  = 500;

   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_type;

   logic clock;
   logic reset;
   logic calm;
   int   stall_cycles;
   int   words_sent;
   int   mismatches;
   int   outstanding;
   int   results_checked;
   int   refusals;
   int   search_hits;

   bdq_pkg::word_type value_pool [8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
                                         32'h7FFF_FFFF, 32'h0000_0001, 32'h0000_0002,
                                         32'h0000_0003, 32'h5A5A_5A5A};

   bdq_req_if req_if ();
   bdq_rsp_if rsp_if ();

   bounded_deque_with_bag_search_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if)
   );

   bdq_result_checker checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_if),
      .rsp_mon         (rsp_if),
      .mismatches      (mismatches),
      .outstanding     (outstanding),
      .results_checked (results_checked),
      .refusals        (refusals),
      .search_hits     (search_hits)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      rsp_if.ready <= calm || ($urandom_range(0, 99) >= 7);
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("tb_bounded_deque_with_bag_search_unit: FAIL");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic send_word(input logic [bdq_pkg::ACTION_W-1:0] act,
                            input bdq_pkg::word_type val);
      req_if.valid  <= 1'b1;
      req_if.action <= act;
      req_if.value  <= val;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      words_sent++;
      if (!calm && $urandom_range(0, 99) < 7) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   function automatic bdq_pkg::word_type pick_value();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return value_pool[$urandom_range(0, 7)];
      return $urandom();
   endfunction

   function automatic logic [bdq_pkg::ACTION_W-1:0] pick_action(input mix_type mix);
      int r;
      r = $urandom_range(0, 99);
      case (mix)
         MIX_FILL: begin
            if (r < 35) return bdq_pkg::ACT_PUSH_FRONT;
            if (r < 70) return bdq_pkg::ACT_PUSH_BACK;
            if (r < 78) return bdq_pkg::ACT_POP_FRONT;
            if (r < 84) return bdq_pkg::ACT_POP_BACK;
            if (r < 90) return bdq_pkg::ACT_CONTAINS;
            if (r < 96) return bdq_pkg::ACT_REMOVE;
         end
         MIX_DRAIN: begin
            if (r < 10) return bdq_pkg::ACT_PUSH_FRONT;
            if (r < 20) return bdq_pkg::ACT_PUSH_BACK;
            if (r < 45) return bdq_pkg::ACT_POP_FRONT;
            if (r < 65) return bdq_pkg::ACT_POP_BACK;
            if (r < 75) return bdq_pkg::ACT_CONTAINS;
            if (r < 96) return bdq_pkg::ACT_REMOVE;
         end
         default: begin
            if (r < 20) return bdq_pkg::ACT_PUSH_FRONT;
            if (r < 40) return bdq_pkg::ACT_PUSH_BACK;
            if (r < 50) return bdq_pkg::ACT_POP_FRONT;
            if (r < 60) return bdq_pkg::ACT_POP_BACK;
            if (r < 76) return bdq_pkg::ACT_CONTAINS;
            if (r < 96) return bdq_pkg::ACT_REMOVE;
         end
      endcase
      if (r < 98) return bdq_pkg::ACT_QUERY;
      return ACT_UNUSED;
   endfunction

   initial begin
      mix_type mix;
      words_sent    = 0;
      reset         <= 1'b1;
      calm          <= 1'b0;
      req_if.valid  <= 1'b0;
      req_if.action <= bdq_pkg::ACT_QUERY;
      req_if.value  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // empty store corner cases, then pushes, searches and removals
      send_word(bdq_pkg::ACT_QUERY, 32'h0000_0000);
      send_word(bdq_pkg::ACT_POP_FRONT, 32'h0000_0000);
      send_word(bdq_pkg::ACT_POP_BACK, 32'h0000_0000);
      send_word(bdq_pkg::ACT_REMOVE, 32'h0000_0000);
      send_word(bdq_pkg::ACT_CONTAINS, 32'h0000_0000);
      send_word(ACT_UNUSED, 32'hFFFF_FFFF);
      send_word(bdq_pkg::ACT_PUSH_FRONT, 32'h8000_0000);
      send_word(bdq_pkg::ACT_PUSH_BACK, 32'h7FFF_FFFF);
      send_word(bdq_pkg::ACT_PUSH_FRONT, 32'hFFFF_FFFF);
      send_word(bdq_pkg::ACT_PUSH_BACK, 32'h0000_0000);
      send_word(bdq_pkg::ACT_CONTAINS, 32'h7FFF_FFFF);
      send_word(bdq_pkg::ACT_CONTAINS, 32'h0001_2345);
      send_word(bdq_pkg::ACT_REMOVE, 32'h0001_2345);
      send_word(bdq_pkg::ACT_REMOVE, 32'h8000_0000);
      send_word(bdq_pkg::ACT_PUSH_BACK, 32'h0000_0000);
      // duplicate values: only the first match goes
      send_word(bdq_pkg::ACT_REMOVE, 32'h0000_0000);
      send_word(bdq_pkg::ACT_QUERY, 32'hA5A5_A5A5);
      send_word(ACT_UNUSED, 32'h5A5A_5A5A);
      send_word(bdq_pkg::ACT_POP_FRONT, 32'h0000_0000);
      send_word(bdq_pkg::ACT_POP_BACK, 32'h0000_0000);
      send_word(bdq_pkg::ACT_POP_BACK, 32'h0000_0000);
      send_word(bdq_pkg::ACT_POP_FRONT, 32'h0000_0000);

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if (i % SEGMENT_LEN == 0) begin
            case ((i / SEGMENT_LEN) % 3)
               0: mix = MIX_FILL;
               1: mix = MIX_EVEN;
               default: mix = MIX_DRAIN;
            endcase
         end
         if (i == 400) calm <= 1'b1;
         if (i == 700) calm <= 1'b0;
         send_word(pick_action(mix), pick_value());
      end
      req_if.valid <= 1'b0;

      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("run covered %0d request words and %0d checked results", words_sent,
               results_checked);
      $display("including %0d full or empty refusals and %0d search matches", refusals,
               search_hits);
      if (mismatches == 0) begin
         $display("tb_bounded_deque_with_bag_search_unit: PASS");
      end else begin
         $display("tb_bounded_deque_with_bag_search_unit: FAIL");
      end
      $finish;
   end

endmodule
